/* src/lmac_pkg.sv */
// Shared types, codes and float32 helper functions for the linear layer MAC engine.
package lmac_pkg;

  localparam int MAX_INPUTS_DEF  = 64;
  localparam int MAX_OUTPUTS_DEF = 64;

  localparam int CNT_W  = 7;
  localparam int CFG_W  = 7;
  localparam int IDX_W  = 2;
  localparam int POS_W  = 6;
  localparam int WORD_W = 32;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_ROW    = 2'd2;

  localparam logic [1:0] ET_F32  = 2'd0;
  localparam logic [1:0] ET_F16  = 2'd1;
  localparam logic [1:0] ET_BF16 = 2'd2;

  localparam logic [IDX_W-1:0] REG_ELEMENT_TYPE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_INPUT_LENGTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_OUTPUT_LENGTH = 2'd2;
  localparam logic [IDX_W-1:0] REG_BIAS_ENABLE   = 2'd3;

  localparam logic [31:0] F32_QNAN  = 32'h7FC0_0000;
  localparam logic [15:0] F16_QNAN  = 16'h7E00;
  localparam logic [15:0] BF16_QNAN = 16'h7FC0;

  typedef struct packed {
    logic [1:0]        operation;
    logic [POS_W-1:0]  output_position;
    logic [POS_W-1:0]  feature_position;
    logic [WORD_W-1:0] data_word;
  } lmac_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  result_position;
    logic [WORD_W-1:0] result_word;
    logic              row_last;
  } lmac_res_t;

  typedef struct packed {
    logic             mac;
    logic [POS_W-1:0] idx;
  } lmac_tag_t;

  typedef struct packed {
    logic        valid;
    lmac_tag_t   tag;
    logic [31:0] x;
    logic [31:0] w;
    logic [31:0] addend;
  } lmac_fma_in_t;

  typedef struct packed {
    logic        valid;
    lmac_tag_t   tag;
    logic [31:0] result;
  } lmac_fma_out_t;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n = 6'(47 - i);
      end
    end
    return n;
  endfunction

  // m has its leading one at bit 47; value = m / 2^47 * 2^(e - 127)
  function automatic logic [31:0] fp_pack(input logic s, input logic signed [10:0] e,
                                          input logic [47:0] m);
    logic [47:0] mm;
    logic        lost;
    logic [5:0]  d;
    logic [30:0] base;
    logic        inc;
    mm = m;
    lost = 1'b0;
    d = 6'd0;
    if (e >= 11'sd255) return {s, 8'hFF, 23'd0};
    if (e >= 11'sd1) begin
      base = {e[7:0], m[46:24]};
    end else begin
      if (e < -11'sd46) begin
        mm = 48'd0;
        lost = |m;
      end else begin
        d = 6'(11'sd1 - e);
        mm = m >> d;
        lost = |(m & ~({48{1'b1}} << d));
      end
      base = {8'd0, mm[46:24]};
    end
    inc = mm[23] & ((|mm[22:0]) | lost | base[0]);
    return {s, base + 31'(inc)};
  endfunction

  function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] p;
    logic [9:0] mn;
    logic [7:0] e;
    ex = h[14:10];
    man = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) p = 4'(i);
    end
    if (ex == 5'd0) begin
      if (man == 10'd0) return {h[15], 31'd0};
      mn = man << (4'd10 - p);
      e = 8'd103 + 8'(p);
      return {h[15], e, mn, 13'd0};
    end
    if (ex == 5'h1F) return {h[15], 8'hFF, man, 13'd0};
    return {h[15], 8'(ex) + 8'd112, man, 13'd0};
  endfunction

  function automatic logic [15:0] f32_to_f16(input logic [31:0] b);
    logic              s;
    logic [7:0]        ex;
    logic [22:0]       man;
    logic signed [9:0] e;
    logic [23:0]       m;
    logic [4:0]        sh;
    logic [23:0]       r;
    logic [23:0]       rem;
    logic [23:0]       half;
    logic [14:0]       rn;
    logic [12:0]       rm;
    s = b[31];
    ex = b[30:23];
    man = b[22:0];
    e = $signed({2'b00, ex}) - 10'sd112;
    if (ex == 8'hFF) return (man != 23'd0) ? F16_QNAN : {s, 15'h7C00};
    if (e >= 10'sd31) return {s, 15'h7C00};
    if (e <= 10'sd0) begin
      if (e < -10'sd10) return {s, 15'd0};
      m = {1'b1, man};
      sh = 5'(10'sd14 - e);
      r = m >> sh;
      rem = m & ((24'd1 << sh) - 24'd1);
      half = 24'd1 << (sh - 5'd1);
      if (rem > half || (rem == half && r[0])) r = r + 24'd1;
      return {s, r[14:0]};
    end
    rn = {e[4:0], man[22:13]};
    rm = man[12:0];
    if (rm > 13'h1000 || (rm == 13'h1000 && rn[0])) rn = rn + 15'd1;
    return {s, rn};
  endfunction

  function automatic logic [31:0] decode_element(input logic [1:0] et, input logic [31:0] raw);
    case (et)
      ET_F16:  return f16_to_f32(raw[15:0]);
      ET_BF16: return {raw[15:0], 16'd0};
      default: return raw;
    endcase
  endfunction

  function automatic logic [31:0] encode_result(input logic [1:0] et, input logic [31:0] b);
    logic        nan;
    logic [32:0] t;
    nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    t = {1'b0, b} + 33'h7FFF + {32'd0, b[16]};
    case (et)
      ET_F16:  return {16'd0, f32_to_f16(b)};
      ET_BF16: return nan ? {16'd0, BF16_QNAN} : {16'd0, t[31:16]};
      default: return nan ? F32_QNAN : b;
    endcase
  endfunction

endpackage

/* src/lmac_fma.sv */
// Pipelined float32 multiply then add (product rounded before the add), one op per cycle.
module lmac_fma (
  input  logic                   clk,
  input  logic                   rst,
  input  lmac_pkg::lmac_fma_in_t req,
  output lmac_pkg::lmac_fma_out_t rsp,
  output logic                   busy
);

  localparam int NS = 6;

  logic [NS-1:0]       vld;
  lmac_pkg::lmac_tag_t tag_q [NS];
  logic [31:0]         add_q [NS];

  // multiply front
  logic [7:0]  fx_e, fw_e;
  logic [22:0] fx_f, fw_f;
  logic        fx_nan, fx_inf, fx_zero, fw_nan, fw_inf, fw_zero;
  logic        mul_sign, mul_spec;
  logic [31:0] mul_sval;
  logic [47:0] mul_prod;
  logic [8:0]  mul_esum;

  logic        m1_sign, m1_spec;
  logic [31:0] m1_sval;
  logic [47:0] m1_prod;
  logic [8:0]  m1_esum;

  logic        m2_sign, m2_spec;
  logic [31:0] m2_sval;
  logic [47:0] m2_prod;
  logic [8:0]  m2_esum;
  logic [5:0]  m2_lz;

  logic signed [10:0] m3_e;
  logic [31:0]        m3_val;
  logic [31:0]        m3_p;

  // add
  logic [31:0] al_a, al_b, al_big, al_sml;
  logic        aa_nan, aa_inf, aa_zero, ab_nan, ab_inf, ab_zero;
  logic        al_spec;
  logic [31:0] al_sval;
  logic [7:0]  al_be, al_se, al_d;
  logic [4:0]  al_dc;
  logic [53:0] al_shv;
  logic [26:0] al_bigm, al_smlm;

  logic        a1_spec, a1_sign, a1_sub;
  logic [31:0] a1_sval;
  logic [7:0]  a1_exp;
  logic [26:0] a1_big, a1_sml;

  logic        a2_spec, a2_sign;
  logic [31:0] a2_sval;
  logic [7:0]  a2_exp;
  logic [27:0] a2_sum;

  logic        a3_spec, a3_sign;
  logic [31:0] a3_sval;
  logic [7:0]  a3_exp;
  logic [27:0] a3_sum;
  logic [5:0]  a3_lz;

  logic signed [10:0] fin_e;
  logic [31:0]        fin_val;

  logic                out_valid;
  lmac_pkg::lmac_tag_t out_tag;
  logic [31:0]         out_result;

  always_comb begin
    fx_e = req.x[30:23];
    fx_f = req.x[22:0];
    fw_e = req.w[30:23];
    fw_f = req.w[22:0];
    fx_nan = (fx_e == 8'hFF) && (fx_f != 23'd0);
    fx_inf = (fx_e == 8'hFF) && (fx_f == 23'd0);
    fx_zero = (req.x[30:0] == 31'd0);
    fw_nan = (fw_e == 8'hFF) && (fw_f != 23'd0);
    fw_inf = (fw_e == 8'hFF) && (fw_f == 23'd0);
    fw_zero = (req.w[30:0] == 31'd0);
    mul_sign = req.x[31] ^ req.w[31];
    mul_prod = {24'd0, |fx_e, fx_f} * {24'd0, |fw_e, fw_f};
    mul_esum = 9'((fx_e == 8'd0) ? 8'd1 : fx_e) + 9'((fw_e == 8'd0) ? 8'd1 : fw_e);
    mul_spec = 1'b1;
    if (fx_nan || fw_nan || (fx_inf && fw_zero) || (fx_zero && fw_inf)) begin
      mul_sval = lmac_pkg::F32_QNAN;
    end else if (fx_inf || fw_inf) begin
      mul_sval = {mul_sign, 8'hFF, 23'd0};
    end else if (fx_zero || fw_zero) begin
      mul_sval = {mul_sign, 31'd0};
    end else begin
      mul_spec = 1'b0;
      mul_sval = 32'd0;
    end
  end

  always_comb begin
    m3_e = $signed({2'b00, m2_esum}) - 11'sd126 - $signed({5'b00000, m2_lz});
    m3_val = m2_spec ? m2_sval : lmac_pkg::fp_pack(m2_sign, m3_e, m2_prod << m2_lz);
  end

  always_comb begin
    al_a = add_q[2];
    al_b = m3_p;
    aa_nan = (al_a[30:23] == 8'hFF) && (al_a[22:0] != 23'd0);
    aa_inf = (al_a[30:23] == 8'hFF) && (al_a[22:0] == 23'd0);
    aa_zero = (al_a[30:0] == 31'd0);
    ab_nan = (al_b[30:23] == 8'hFF) && (al_b[22:0] != 23'd0);
    ab_inf = (al_b[30:23] == 8'hFF) && (al_b[22:0] == 23'd0);
    ab_zero = (al_b[30:0] == 31'd0);
    al_spec = 1'b1;
    if (aa_nan || ab_nan || (aa_inf && ab_inf && (al_a[31] != al_b[31]))) begin
      al_sval = lmac_pkg::F32_QNAN;
    end else if (aa_inf) begin
      al_sval = al_a;
    end else if (ab_inf) begin
      al_sval = al_b;
    end else if (aa_zero && ab_zero) begin
      al_sval = {al_a[31] & al_b[31], 31'd0};
    end else begin
      al_spec = 1'b0;
      al_sval = 32'd0;
    end
    if (al_b[30:0] > al_a[30:0]) begin
      al_big = al_b;
      al_sml = al_a;
    end else begin
      al_big = al_a;
      al_sml = al_b;
    end
    al_be = (al_big[30:23] == 8'd0) ? 8'd1 : al_big[30:23];
    al_se = (al_sml[30:23] == 8'd0) ? 8'd1 : al_sml[30:23];
    al_d = al_be - al_se;
    al_dc = (al_d > 8'd27) ? 5'd27 : al_d[4:0];
    al_shv = {|al_sml[30:23], al_sml[22:0], 3'b000, 27'd0} >> al_dc;
    al_smlm = al_shv[53:27] | {26'd0, |al_shv[26:0]};
    al_bigm = {|al_big[30:23], al_big[22:0], 3'b000};
  end

  always_comb begin
    fin_e = 11'sd1 + $signed({3'b000, a3_exp}) - $signed({5'b00000, a3_lz});
    if (a3_spec) begin
      fin_val = a3_sval;
    end else if (a3_sum == 28'd0) begin
      fin_val = 32'd0;
    end else begin
      fin_val = lmac_pkg::fp_pack(a3_sign, fin_e, {a3_sum, 20'd0} << a3_lz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else begin
      vld <= {vld[NS-2:0], req.valid};
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    tag_q[0] <= req.tag;
    add_q[0] <= req.addend;
    for (int i = 1; i < NS; i++) begin
      tag_q[i] <= tag_q[i-1];
      add_q[i] <= add_q[i-1];
    end

    m1_sign <= mul_sign;
    m1_spec <= mul_spec;
    m1_sval <= mul_sval;
    m1_prod <= mul_prod;
    m1_esum <= mul_esum;

    m2_sign <= m1_sign;
    m2_spec <= m1_spec;
    m2_sval <= m1_sval;
    m2_prod <= m1_prod;
    m2_esum <= m1_esum;
    m2_lz <= lmac_pkg::lzc48(m1_prod);

    m3_p <= m3_val;

    a1_spec <= al_spec;
    a1_sval <= al_sval;
    a1_sign <= al_big[31];
    a1_sub <= al_big[31] ^ al_sml[31];
    a1_exp <= al_be;
    a1_big <= al_bigm;
    a1_sml <= al_smlm;

    a2_spec <= a1_spec;
    a2_sval <= a1_sval;
    a2_sign <= a1_sign;
    a2_exp <= a1_exp;
    a2_sum <= a1_sub ? ({1'b0, a1_big} - {1'b0, a1_sml}) : ({1'b0, a1_big} + {1'b0, a1_sml});

    a3_spec <= a2_spec;
    a3_sval <= a2_sval;
    a3_sign <= a2_sign;
    a3_exp <= a2_exp;
    a3_sum <= a2_sum;
    a3_lz <= lmac_pkg::lzc48({a2_sum, 20'd0});

    out_tag <= tag_q[NS-1];
    out_result <= tag_q[NS-1].mac ? fin_val : add_q[NS-1];
  end

  assign rsp = '{valid: out_valid, tag: out_tag, result: out_result};
  assign busy = (|vld) | out_valid;

endmodule

/* src/linear_layer_mac_engine.sv */
// Top level: configuration, weight/bias/accumulator memories, row sequencer and result port.
//
//  channel   dir  handshake              payload
//  cfg       in   cfg_write              cfg_index, cfg_data
//  request   in   req_valid/req_ready    req_data (operation, positions, data_word)
//  result    out  res_valid/res_ready    res_data (result_position, result_word, row_last)
//
// A weight or bias load in range is written when the request is accepted. A row element
// sweeps the accumulator memory through the multiply-add pipeline, one entry per cycle,
// then drains it: O entries, or all MAX_OUTPUTS entries on the first element of a row
// (every accumulator is reloaded). After the last element results are read, loaded and held.
// Synchronous reset initialises control and configuration; the memories are not cleared.
module linear_layer_mac_engine #(
  parameter int MAX_INPUTS  = lmac_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = lmac_pkg::MAX_OUTPUTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lmac_pkg::IDX_W-1:0]       cfg_index,
  input  logic [lmac_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  lmac_pkg::lmac_req_t              req_data,
  output logic                             res_valid,
  input  logic                             res_ready,
  output lmac_pkg::lmac_res_t              res_data
);

  localparam int KW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int OW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int OCW = $clog2(MAX_OUTPUTS + 1);
  localparam int WAW = OW + KW;
  localparam int CW  = lmac_pkg::CNT_W;
  localparam int PW  = lmac_pkg::POS_W;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_MAC       = 3'd1;
  localparam logic [2:0] S_DRAIN     = 3'd2;
  localparam logic [2:0] S_EMIT_RD   = 3'd3;
  localparam logic [2:0] S_EMIT_LD   = 3'd4;
  localparam logic [2:0] S_EMIT_HOLD = 3'd5;

  logic [1:0]    element_type;
  logic [CW-1:0] input_length;
  logic [CW-1:0] output_length;
  logic          bias_enable;

  logic [CW-1:0]  klen;
  logic [OCW-1:0] olen;
  logic [KW-1:0]  kidx;

  logic [2:0]     state;
  logic [OCW-1:0] idx;
  logic [OCW-1:0] last_idx;
  logic [CW-1:0]  counter;
  logic [CW-1:0]  counter_next;
  logic           row_init;
  logic [31:0]    x_raw;

  logic                s1_valid;
  lmac_pkg::lmac_tag_t s1_tag;
  logic                s1_init;

  logic [31:0] wmem [1 << WAW];
  logic [31:0] bmem [1 << OW];
  logic [31:0] amem [1 << OW];
  logic [31:0] w_rd, b_rd, a_rd;

  logic req_fire;
  logic w_we, b_we;
  logic [OW-1:0] ld_o;
  logic [KW-1:0] ld_k;

  lmac_pkg::lmac_fma_in_t  fma_in;
  lmac_pkg::lmac_fma_out_t fma_out;
  logic                    fma_busy;
  logic [31:0]             init_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_type <= lmac_pkg::ET_F32;
      input_length <= CW'(64);
      output_length <= CW'(64);
      bias_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        lmac_pkg::REG_ELEMENT_TYPE:  element_type <= cfg_data[1:0];
        lmac_pkg::REG_INPUT_LENGTH:  input_length <= cfg_data;
        lmac_pkg::REG_OUTPUT_LENGTH: output_length <= cfg_data;
        lmac_pkg::REG_BIAS_ENABLE:   bias_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (input_length == '0) begin
      klen = CW'(1);
    end else if (32'(input_length) > MAX_INPUTS) begin
      klen = CW'(MAX_INPUTS);
    end else begin
      klen = input_length;
    end
    if (output_length == '0) begin
      olen = OCW'(1);
    end else if (32'(output_length) > MAX_OUTPUTS) begin
      olen = OCW'(MAX_OUTPUTS);
    end else begin
      olen = OCW'(output_length);
    end
    if (32'(counter) < MAX_INPUTS) begin
      kidx = KW'(counter);
    end else begin
      kidx = KW'(MAX_INPUTS - 1);
    end
    last_idx = row_init ? OCW'(MAX_OUTPUTS - 1) : (olen - OCW'(1));
    counter_next = counter + CW'(1);
  end

  assign req_ready = (state == S_IDLE);
  assign req_fire = req_valid && req_ready;
  assign ld_o = OW'(req_data.output_position);
  assign ld_k = KW'(req_data.feature_position);
  assign w_we = req_fire && (req_data.operation == lmac_pkg::OP_WEIGHT)
             && (32'(req_data.output_position) < MAX_OUTPUTS)
             && (32'(req_data.feature_position) < MAX_INPUTS);
  assign b_we = req_fire && (req_data.operation == lmac_pkg::OP_BIAS)
             && (32'(req_data.output_position) < MAX_OUTPUTS);

  always_ff @(posedge clk) begin
    if (w_we) wmem[{ld_o, ld_k}] <= req_data.data_word;
    w_rd <= wmem[{idx[OW-1:0], kidx}];
  end

  always_ff @(posedge clk) begin
    if (b_we) bmem[ld_o] <= req_data.data_word;
    b_rd <= bmem[idx[OW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fma_out.valid) amem[fma_out.tag.idx[OW-1:0]] <= fma_out.result;
    a_rd <= amem[idx[OW-1:0]];
  end

  always_comb begin
    init_val = bias_enable ? lmac_pkg::decode_element(element_type, b_rd) : 32'd0;
    fma_in.valid = s1_valid;
    fma_in.tag = s1_tag;
    fma_in.x = lmac_pkg::decode_element(element_type, x_raw);
    fma_in.w = lmac_pkg::decode_element(element_type, w_rd);
    fma_in.addend = s1_init ? init_val : a_rd;
  end

  lmac_fma u_fma (
    .clk  (clk),
    .rst  (rst),
    .req  (fma_in),
    .rsp  (fma_out),
    .busy (fma_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      counter <= '0;
      s1_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_fire && req_data.operation == lmac_pkg::OP_ROW) begin
            state <= S_MAC;
            idx <= '0;
            row_init <= (counter == '0);
            x_raw <= req_data.data_word;
          end
        end
        S_MAC: begin
          s1_valid <= 1'b1;
          s1_tag.mac <= (idx < olen);
          s1_tag.idx <= PW'(idx);
          s1_init <= row_init;
          if (idx == last_idx) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + OCW'(1);
          end
        end
        S_DRAIN: begin
          if (!s1_valid && !fma_busy) begin
            idx <= '0;
            if (counter_next >= klen) begin
              counter <= '0;
              state <= S_EMIT_RD;
            end else begin
              counter <= counter_next;
              state <= S_IDLE;
            end
          end
        end
        S_EMIT_RD: state <= S_EMIT_LD;
        S_EMIT_LD: begin
          res_data.result_position <= PW'(idx);
          res_data.result_word <= lmac_pkg::encode_result(element_type, a_rd);
          res_data.row_last <= (idx == olen - OCW'(1));
          res_valid <= 1'b1;
          state <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            if (res_data.row_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + OCW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_res_in_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> state == S_EMIT_HOLD)
    else $error("result valid outside hold state");

  a_ready_idle_pipe: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !fma_busy && !s1_valid)
    else $error("request taken while multiply-add pipeline busy");

  a_last_position: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.row_last |-> res_data.result_position == PW'(olen - OCW'(1)))
    else $error("row_last on wrong position");

  a_acc_write_window: assert property (@(posedge clk) disable iff (rst)
    fma_out.valid |-> state == S_MAC || state == S_DRAIN)
    else $error("accumulator write outside element sweep");

endmodule

/* tb/lmac_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the linear layer MAC engine: float32 row predictor and result scoreboard.
module lmac_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [lmac_pkg::IDX_W-1:0] cfg_index,
  input  logic [lmac_pkg::CFG_W-1:0] cfg_data,
  input  logic                       req_valid,
  input  logic                       req_ready,
  input  lmac_pkg::lmac_req_t        req_data,
  input  logic                       res_valid,
  input  logic                       res_ready,
  input  lmac_pkg::lmac_res_t        res_data,
  output int                         fail_count,
  output int                         pending
);

  logic [1:0]          cfg_et;
  logic [6:0]          cfg_k;
  logic [6:0]          cfg_o;
  logic                cfg_bias;
  logic [6:0]          row_count;
  logic [31:0]         weight_words [4096];
  logic [31:0]         bias_words [64];
  logic [31:0]         acc_words [64];
  lmac_pkg::lmac_res_t expected_outputs [$];
  int                  errors;

  initial begin
    for (int i = 0; i < 4096; i++) weight_words[i] = '0;
    for (int i = 0; i < 64; i++) begin
      bias_words[i] = '0;
      acc_words[i] = '0;
    end
  end

  function automatic bit is_nan32(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 23'd0;
  endfunction

  function automatic bit is_inf32(logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == 23'd0;
  endfunction

  function automatic bit is_zero32(logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic [31:0] half_to_f32(logic [15:0] h);
    logic [10:0] mm;
    int          e;
    if (h[14:10] == 5'd0) begin
      if (h[9:0] == 10'd0) return {h[15], 31'd0};
      mm = {1'b0, h[9:0]};
      e = 113;
      while (!mm[10]) begin
        mm = mm << 1;
        e--;
      end
      return {h[15], 8'(e), mm[9:0], 13'd0};
    end
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'(int'(h[14:10]) + 112), h[9:0], 13'd0};
  endfunction

  function automatic logic [15:0] f32_to_half(logic [31:0] b);
    logic [15:0] sgn;
    int          ex;
    int          e;
    int          sh;
    logic [31:0] m;
    logic [31:0] r;
    logic [31:0] rem;
    logic [31:0] hf;
    sgn = {b[31], 15'd0};
    ex = int'(b[30:23]);
    if (ex == 255) return (b[22:0] != 23'd0) ? lmac_pkg::F16_QNAN : (sgn | 16'h7C00);
    e = ex - 112;
    if (e >= 31) return sgn | 16'h7C00;
    if (e <= 0) begin
      if (e < -10) return sgn;
      m = {9'd0, 1'b1, b[22:0]};
      sh = 14 - e;
      r = m >> sh;
      rem = m & ((32'd1 << sh) - 32'd1);
      hf = 32'd1 << (sh - 1);
      if (rem > hf || (rem == hf && r[0])) r = r + 32'd1;
      return sgn | r[15:0];
    end
    r = (32'(e) << 10) | {22'd0, b[22:13]};
    rem = {19'd0, b[12:0]};
    if (rem > 32'h1000 || (rem == 32'h1000 && r[0])) r = r + 32'd1;
    return sgn | r[15:0];
  endfunction

  function automatic logic [31:0] widen_word(logic [1:0] et, logic [31:0] raw);
    case (et)
      lmac_pkg::ET_F16:  return half_to_f32(raw[15:0]);
      lmac_pkg::ET_BF16: return {raw[15:0], 16'd0};
      default: return raw;
    endcase
  endfunction

  function automatic logic [31:0] narrow_word(logic [1:0] et, logic [31:0] b);
    logic [32:0] t;
    t = {1'b0, b} + 33'h7FFF + {32'd0, b[16]};
    case (et)
      lmac_pkg::ET_F16:  return {16'd0, f32_to_half(b)};
      lmac_pkg::ET_BF16: return is_nan32(b) ? {16'd0, lmac_pkg::BF16_QNAN} : {16'd0, t[31:16]};
      default: return is_nan32(b) ? lmac_pkg::F32_QNAN : b;
    endcase
  endfunction

  // value = sig * 2^e2, sig nonzero; round to nearest even into float32
  function automatic logic [31:0] round_f32(logic s, int e2, logic [127:0] sig);
    int           p;
    int           sh;
    int           bexp;
    logic [127:0] m;
    logic [127:0] rem;
    logic [127:0] hf;
    p = 0;
    for (int i = 0; i < 128; i++) if (sig[i]) p = i;
    sh = p - 23;
    if (sh < -149 - e2) sh = -149 - e2;
    if (sh > p + 1) begin
      m = '0;
    end else if (sh > 0) begin
      m = sig >> sh;
      rem = sig & ((128'd1 << sh) - 128'd1);
      hf = 128'd1 << (sh - 1);
      if (rem > hf || (rem == hf && m[0])) m = m + 128'd1;
    end else begin
      m = sig << (-sh);
    end
    if (m[24]) begin
      m = m >> 1;
      sh++;
    end
    if (m == '0) return {s, 31'd0};
    bexp = m[23] ? e2 + sh + 150 : 0;
    if (bexp >= 255) return {s, 8'hFF, 23'd0};
    return {s, 8'(bexp), m[22:0]};
  endfunction

  function automatic void split_f32(logic [31:0] a, output int e, output logic [23:0] m);
    if (a[30:23] == 8'd0) begin
      m = {1'b0, a[22:0]};
      e = -149;
    end else begin
      m = {1'b1, a[22:0]};
      e = int'(a[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic        s;
    int          ea;
    int          eb;
    logic [23:0] ma;
    logic [23:0] mb;
    s = a[31] ^ b[31];
    if (is_nan32(a) || is_nan32(b)) return lmac_pkg::F32_QNAN;
    if (is_inf32(a) || is_inf32(b)) begin
      if (is_zero32(a) || is_zero32(b)) return lmac_pkg::F32_QNAN;
      return {s, 8'hFF, 23'd0};
    end
    if (is_zero32(a) || is_zero32(b)) return {s, 31'd0};
    split_f32(a, ea, ma);
    split_f32(b, eb, mb);
    return round_f32(s, ea + eb, 128'(ma) * 128'(mb));
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    logic [31:0]  big;
    logic [31:0]  sml;
    int           ea;
    int           eb;
    int           d;
    logic [23:0]  ma;
    logic [23:0]  mb;
    logic [127:0] wa;
    logic [127:0] wb;
    if (is_nan32(a) || is_nan32(b)) return lmac_pkg::F32_QNAN;
    if (is_inf32(a) && is_inf32(b)) return (a[31] != b[31]) ? lmac_pkg::F32_QNAN : a;
    if (is_inf32(a)) return a;
    if (is_inf32(b)) return b;
    if (is_zero32(a) && is_zero32(b)) return {a[31] & b[31], 31'd0};
    if (is_zero32(a)) return b;
    if (is_zero32(b)) return a;
    big = (a[30:0] >= b[30:0]) ? a : b;
    sml = (a[30:0] >= b[30:0]) ? b : a;
    split_f32(big, ea, ma);
    split_f32(sml, eb, mb);
    d = ea - eb;
    if (d > 80) return big;
    wa = 128'(ma) << d;
    wb = 128'(mb);
    if (big[31] == sml[31]) return round_f32(big[31], eb, wa + wb);
    if (wa == wb) return 32'd0;
    return round_f32(big[31], eb, wa - wb);
  endfunction

  task automatic absorb_request(lmac_pkg::lmac_req_t r);
    int                  klen;
    int                  olen;
    int                  k;
    logic [31:0]         x;
    lmac_pkg::lmac_res_t item;
    klen = (cfg_k < 1) ? 1 : ((cfg_k > 64) ? 64 : int'(cfg_k));
    olen = (cfg_o < 1) ? 1 : ((cfg_o > 64) ? 64 : int'(cfg_o));
    case (r.operation)
      lmac_pkg::OP_WEIGHT: weight_words[{r.output_position, r.feature_position}] = r.data_word;
      lmac_pkg::OP_BIAS:   bias_words[r.output_position] = r.data_word;
      lmac_pkg::OP_ROW: begin
        if (row_count == 0)
          for (int i = 0; i < 64; i++)
            acc_words[i] = cfg_bias ? widen_word(cfg_et, bias_words[i]) : 32'd0;
        x = widen_word(cfg_et, r.data_word);
        k = (row_count < 64) ? int'(row_count) : 63;
        for (int i = 0; i < olen; i++)
          acc_words[i] = f32_add(acc_words[i],
                                 f32_mul(x, widen_word(cfg_et, weight_words[i * 64 + k])));
        row_count = row_count + 7'd1;
        if (int'(row_count) >= klen) begin
          row_count = '0;
          for (int i = 0; i < olen; i++) begin
            item.result_position = lmac_pkg::POS_W'(i);
            item.result_word = narrow_word(cfg_et, acc_words[i]);
            item.row_last = (i + 1 == olen);
            expected_outputs.push_back(item);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    lmac_pkg::lmac_res_t want;
    if (rst) begin
      cfg_et = lmac_pkg::ET_F32;
      cfg_k = 7'd64;
      cfg_o = 7'd64;
      cfg_bias = 1'b0;
      row_count = '0;
      expected_outputs.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (expected_outputs.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: pos %0d word %h last %b",
                     res_data.result_position, res_data.result_word, res_data.row_last);
        end else begin
          want = expected_outputs.pop_front();
          if (res_data.result_position !== want.result_position ||
              res_data.result_word !== want.result_word ||
              res_data.row_last !== want.row_last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected pos %0d word %h last %b, got pos %0d word %h last %b",
                       want.result_position, want.result_word, want.row_last,
                       res_data.result_position, res_data.result_word, res_data.row_last);
          end
        end
      end
      if (req_valid && req_ready) absorb_request(req_data);
      if (cfg_write) begin
        case (cfg_index)
          lmac_pkg::REG_ELEMENT_TYPE:  cfg_et = cfg_data[1:0];
          lmac_pkg::REG_INPUT_LENGTH:  cfg_k = cfg_data;
          lmac_pkg::REG_OUTPUT_LENGTH: cfg_o = cfg_data;
          lmac_pkg::REG_BIAS_ENABLE:   cfg_bias = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending <= expected_outputs.size();
    fail_count <= errors;
  end

endmodule

/* tb/linear_layer_mac_engine_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the linear layer MAC engine: stimulus phases, config sweeps and verdict.
module linear_layer_mac_engine_tb;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] ET_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 100;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [lmac_pkg::IDX_W-1:0] cfg_index = '0;
  logic [lmac_pkg::CFG_W-1:0] cfg_data = '0;
  logic                       req_valid = 1'b0;
  logic                       req_ready;
  lmac_pkg::lmac_req_t        req_data = '0;
  logic                       res_valid;
  logic                       res_ready = 1'b0;
  lmac_pkg::lmac_res_t        res_data;
  int                         fail_count;
  int                         pending;

  int         cycles = 0;
  bit         quiet = 1'b0;
  logic [1:0] cur_et = lmac_pkg::ET_F32;
  int         cur_k = 64;
  int         cur_o = 64;
  bit         cur_bias = 1'b0;
  int         row_pos = 0;
  bit         weight_loaded [64][64];
  bit         bias_loaded [64];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  linear_layer_mac_engine uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
  );

  lmac_result_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[linear_layer_mac_engine] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] random_word(logic [1:0] et);
    int          pick;
    logic [31:0] hi;
    logic [31:0] f32_set [10];
    logic [15:0] f16_set [10];
    logic [15:0] bf16_set [10];
    f32_set = '{32'h0, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
                32'h7F800001, 32'h00000001, 32'h807FFFFF, 32'h7F7FFFFF, 32'h00800000};
    f16_set = '{16'h0, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                16'h7C01, 16'h0001, 16'h83FF, 16'h7BFF, 16'h0400};
    bf16_set = '{16'h0, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0,
                 16'h7F81, 16'h0001, 16'h807F, 16'h7F7F, 16'h0080};
    pick = $urandom_range(0, 99);
    hi = {16'($urandom_range(0, 65535)), 16'd0};
    if (pick < 8) begin
      case (et)
        lmac_pkg::ET_F16:  return hi | {16'd0, f16_set[$urandom_range(0, 9)]};
        lmac_pkg::ET_BF16: return hi | {16'd0, bf16_set[$urandom_range(0, 9)]};
        default: return f32_set[$urandom_range(0, 9)];
      endcase
    end
    if (pick < 30) return $urandom;
    case (et)
      lmac_pkg::ET_F16: return hi | {16'd0, 1'($urandom_range(0, 1)),
                                     5'($urandom_range(9, 21)), 10'($urandom)};
      lmac_pkg::ET_BF16: return hi | {16'd0, 1'($urandom_range(0, 1)),
                                      8'($urandom_range(121, 133)), 7'($urandom)};
      default: return {1'($urandom_range(0, 1)), 8'($urandom_range(121, 133)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_req(logic [1:0] op, int o, int k, logic [31:0] data);
    lmac_pkg::lmac_req_t item;
    int                  gap;
    item.operation = op;
    item.output_position = lmac_pkg::POS_W'(o);
    item.feature_position = lmac_pkg::POS_W'(k);
    item.data_word = data;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    case (op)
      lmac_pkg::OP_WEIGHT: weight_loaded[o][k] = 1'b1;
      lmac_pkg::OP_BIAS:   bias_loaded[o] = 1'b1;
      lmac_pkg::OP_ROW: begin
        row_pos++;
        if (row_pos >= cur_k) row_pos = 0;
      end
      default: ;
    endcase
  endtask

  task automatic send_row_element();
    send_req(lmac_pkg::OP_ROW, $urandom_range(0, 63), $urandom_range(0, 63),
             random_word(cur_et));
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic [1:0] et, int kw, int ow, bit be);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= lmac_pkg::REG_ELEMENT_TYPE;
    cfg_data <= lmac_pkg::CFG_W'(et);
    @(posedge clk);
    cfg_index <= lmac_pkg::REG_INPUT_LENGTH;
    cfg_data <= lmac_pkg::CFG_W'(kw);
    @(posedge clk);
    cfg_index <= lmac_pkg::REG_OUTPUT_LENGTH;
    cfg_data <= lmac_pkg::CFG_W'(ow);
    @(posedge clk);
    cfg_index <= lmac_pkg::REG_BIAS_ENABLE;
    cfg_data <= lmac_pkg::CFG_W'(be);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_et = et;
    cur_k = (kw < 1) ? 1 : ((kw > 64) ? 64 : kw);
    cur_o = (ow < 1) ? 1 : ((ow > 64) ? 64 : ow);
    cur_bias = be;
  endtask

  // every weight and bias the next rows read must have been loaded
  task automatic fill_stores();
    for (int o = 0; o < cur_o; o++)
      for (int k = 0; k < cur_k; k++)
        if (!weight_loaded[o][k]) send_req(lmac_pkg::OP_WEIGHT, o, k, random_word(cur_et));
    if (cur_bias)
      for (int o = 0; o < cur_o; o++)
        if (!bias_loaded[o])
          send_req(lmac_pkg::OP_BIAS, o, $urandom_range(0, 63), random_word(cur_et));
  endtask

  task automatic run_phase(logic [1:0] et, int kw, int ow, bit be, int count);
    int done;
    int pick;
    int o;
    int k;
    configure(et, kw, ow, be);
    fill_stores();
    quiet = ($urandom_range(0, 3) == 0);
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_row_element();
        done++;
      end else if (pick < 75) begin
        if ($urandom_range(0, 1)) begin
          o = $urandom_range(0, cur_o - 1);
          k = $urandom_range(0, cur_k - 1);
        end else begin
          o = $urandom_range(0, 63);
          k = $urandom_range(0, 63);
        end
        send_req(lmac_pkg::OP_WEIGHT, o, k, random_word(cur_et));
        done++;
      end else if (pick < 88) begin
        send_req(lmac_pkg::OP_BIAS, $urandom_range(0, 63), $urandom_range(0, 63),
                 random_word(cur_et));
        done++;
      end else if (pick < 95) begin
        send_req(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      end else if (row_pos == 0) begin
        drain();
      end
    end
    while (row_pos != 0) send_row_element();
    quiet = 1'b0;
  endtask

  initial begin : result_sink
    int gap;
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // specials: inf*0, overflow, subnormals, NaN, signed zero, top positions
    configure(lmac_pkg::ET_F32, 2, 2, 1'b1);
    send_req(lmac_pkg::OP_WEIGHT, 0, 0, 32'h7F800000);
    send_req(lmac_pkg::OP_WEIGHT, 0, 1, 32'h3F800000);
    send_req(lmac_pkg::OP_WEIGHT, 1, 0, 32'h00000001);
    send_req(lmac_pkg::OP_WEIGHT, 1, 1, 32'h7F7FFFFF);
    send_req(lmac_pkg::OP_WEIGHT, 63, 63, 32'hFFFFFFFF);
    send_req(lmac_pkg::OP_BIAS, 0, 63, 32'h80000000);
    send_req(lmac_pkg::OP_BIAS, 1, 0, 32'h7F7FFFFF);
    send_req(lmac_pkg::OP_BIAS, 63, 63, 32'hFFFFFFFF);
    send_req(lmac_pkg::OP_ROW, 63, 63, 32'h00000000);
    send_req(lmac_pkg::OP_ROW, 0, 0, 32'h3F800000);
    send_req(lmac_pkg::OP_ROW, 0, 0, 32'h40000000);
    send_req(lmac_pkg::OP_ROW, 0, 0, 32'h7F7FFFFF);
    send_req(OP_UNUSED, 63, 63, 32'hFFFFFFFF);
    send_req(lmac_pkg::OP_ROW, 0, 0, 32'h80000000);
    send_req(lmac_pkg::OP_ROW, 0, 0, 32'h00800000);
    send_req(lmac_pkg::OP_ROW, 0, 0, 32'h7FC00001);
    send_req(lmac_pkg::OP_ROW, 0, 0, 32'hBF800000);

    run_phase(lmac_pkg::ET_F32, 3, 4, 1'b0, 12);
    run_phase(lmac_pkg::ET_F16, 0, 5, 1'b1, 10);
    run_phase(lmac_pkg::ET_BF16, 4, 0, 1'b1, 10);
    run_phase(ET_RESERVED, 127, 1, 1'b0, 4);
    run_phase(lmac_pkg::ET_F16, 1, 127, 1'b0, 8);
    run_phase(lmac_pkg::ET_BF16, 5, 3, 1'b0, 10);
    run_phase(lmac_pkg::ET_F32, 2, 8, 1'b1, 10);
    run_phase(lmac_pkg::ET_F16, 6, 2, 1'b0, 10);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("[linear_layer_mac_engine] OK");
    end else begin
      $display("[linear_layer_mac_engine] ERROR");
    end
    $finish;
  end

endmodule
